### src/tmct_pkg.sv
package tmct_pkg;

    // Storage sizes
    localparam int MAP_ENTRIES = 4096;
    localparam int SHAPE_COUNT = 64;
    localparam int MAP_AW      = $clog2(MAP_ENTRIES);
    localparam int SHAPE_AW    = $clog2(SHAPE_COUNT);
    localparam int MASK_DEPTH  = SHAPE_COUNT * 16;
    localparam int MASK_AW     = SHAPE_AW + 4;

    // Field and datapath widths
    localparam int SHAPE_W = 6;     // shape id held in one map entry
    localparam int ROW_W   = 16;    // one mask row
    localparam int TPR_W   = 13;    // tiles_per_row
    localparam int PIX_W   = 15;    // map size in pixels
    localparam int CFG_W   = 15;    // widest register
    localparam int TILE_W  = 11;    // tile coordinate inside a 15-bit pixel range
    localparam int IDX_W   = TILE_W + TPR_W + 1;

    // Mask constants: MSB is column 0
    localparam logic [ROW_W-1:0] ALL_COLS  = 16'hFFFF;
    localparam logic [ROW_W-1:0] TAIL_COLS = 16'h7FFF;
    localparam logic [3:0]       LAST_ROW  = 4'd15;

    // Reserved shapes
    localparam logic [SHAPE_W-1:0] SHAPE_EMPTY = 6'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_FULL  = 6'd1;

    // Register reset values
    localparam logic [TPR_W-1:0] TPR_RESET    = 13'd64;
    localparam logic [PIX_W-1:0] WIDTH_RESET  = 15'd1024;
    localparam logic [PIX_W-1:0] HEIGHT_RESET = 15'd1024;

    typedef enum logic [1:0] {
        MODE_WR_TILE = 2'd0,
        MODE_WR_MASK = 2'd1,
        MODE_POINT   = 2'd2,
        MODE_AREA    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_TILES_PER_ROW = 2'd0,
        CFG_MAP_WIDTH     = 2'd1,
        CFG_MAP_HEIGHT    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic [14:0]         rect_w;
        logic [14:0]         rect_h;
        logic [11:0]         tile_addr;
        logic [5:0]          tile_shape;
        logic [5:0]          mask_shape;
        logic [3:0]          mask_row;
        logic [15:0]         row_bits;
    } cmd_item_t;

    typedef struct packed {
        logic solid;
    } rsp_item_t;

    typedef struct packed {
        logic [TPR_W-1:0] tiles_per_row;
        logic [PIX_W-1:0] map_width_px;
        logic [PIX_W-1:0] map_height_px;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [MAP_AW-1:0]  waddr;
        logic [SHAPE_W-1:0] wdata;
        logic               re;
        logic [MAP_AW-1:0]  raddr;
    } tile_port_t;

    typedef struct packed {
        logic               we;
        logic [MASK_AW-1:0] waddr;
        logic [ROW_W-1:0]   wdata;
        logic               re;
        logic [MASK_AW-1:0] raddr;
    } mask_port_t;

endpackage

### src/tmct_stream_if.sv
interface tmct_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### src/tmct_ram.sv
module tmct_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/tmct_ctrl.sv
module tmct_ctrl
    import tmct_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tmct_stream_if.sink        cmd,
    tmct_stream_if.source      rsp,
    input  cfg_t               cfg,
    output tile_port_t         tile_port,
    input  logic [SHAPE_W-1:0] tile_rdata,
    output mask_port_t         mask_port,
    input  logic [ROW_W-1:0]   mask_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TILE,
        S_SHAPE,
        S_ROW,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_solid_reg, out_solid_next;

    // Query datapath
    logic signed [15:0]  x_reg, x_next;
    logic signed [15:0]  y_reg, y_next;
    logic [14:0]         w_reg, w_next;
    logic [14:0]         h_reg, h_next;
    logic [TILE_W-1:0]   tx0_reg, tx0_next, tx1_reg, tx1_next;
    logic [TILE_W-1:0]   ty0_reg, ty0_next, ty1_reg, ty1_next;
    logic [TILE_W-1:0]   tx_reg, tx_next, ty_reg, ty_next;
    logic [3:0]          px1_lo_reg, px1_lo_next, py1_lo_reg, py1_lo_next;
    logic [IDX_W-1:0]    row_base_reg, row_base_next;
    logic [SHAPE_AW-1:0] shape_reg, shape_next;
    logic [3:0]          row_reg, row_next, last_row_reg, last_row_next;
    logic [ROW_W-1:0]    mk_reg, mk_next;
    logic                res_reg, res_next;

    logic               cmd_accept;
    logic [15:0]        x_end, y_end, px1, py1;
    logic               empty, outside;
    logic [IDX_W-1:0]   ty0_ext, tpr_ext, tx_ext, idx;
    logic               idx_in_map;
    logic               last_tx, last_ty;
    logic [3:0]         c0, c1, r0, r1;
    logic               finish, finish_res, step_tile;

    assign cmd_accept = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.item   = '{solid: out_solid_reg};

    // Bounds of the rectangle (x, y known non-negative when used)
    assign x_end   = {1'b0, x_reg[14:0]} + {1'b0, w_reg};
    assign y_end   = {1'b0, y_reg[14:0]} + {1'b0, h_reg};
    assign px1     = x_end - 16'd1;
    assign py1     = y_end - 16'd1;
    assign empty   = (w_reg == '0) || (h_reg == '0);
    assign outside = x_reg[15] || y_reg[15]
                     || (x_end > {1'b0, cfg.map_width_px})
                     || (y_end > {1'b0, cfg.map_height_px});

    // Tile index from a running row base
    assign ty0_ext    = {{(IDX_W-TILE_W){1'b0}}, y_reg[14:4]};
    assign tpr_ext    = {{(IDX_W-TPR_W){1'b0}}, cfg.tiles_per_row};
    assign tx_ext     = {{(IDX_W-TILE_W){1'b0}}, tx_reg};
    assign idx        = row_base_reg + tx_ext;
    assign idx_in_map = (idx < IDX_W'(MAP_ENTRIES));

    // Clip of columns and rows inside the current tile
    assign last_tx = (tx_reg == tx1_reg);
    assign last_ty = (ty_reg == ty1_reg);
    assign c0      = (tx_reg == tx0_reg) ? x_reg[3:0] : 4'd0;
    assign c1      = last_tx ? px1_lo_reg : LAST_ROW;
    assign r0      = (ty_reg == ty0_reg) ? y_reg[3:0] : 4'd0;
    assign r1      = last_ty ? py1_lo_reg : LAST_ROW;

    // Sequencer: tile read, then one mask row read per cycle
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_solid_next = out_solid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        tx0_next       = tx0_reg;
        tx1_next       = tx1_reg;
        ty0_next       = ty0_reg;
        ty1_next       = ty1_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        px1_lo_next    = px1_lo_reg;
        py1_lo_next    = py1_lo_reg;
        row_base_next  = row_base_reg;
        shape_next     = shape_reg;
        row_next       = row_reg;
        last_row_next  = last_row_reg;
        mk_next        = mk_reg;
        res_next       = res_reg;
        finish         = 1'b0;
        finish_res     = 1'b0;
        step_tile      = 1'b0;

        // Writes go straight to the stores in the accept cycle
        tile_port.we    = cmd_accept && (cmd.item.mode == MODE_WR_TILE)
                          && (32'(cmd.item.tile_addr) < MAP_ENTRIES);
        tile_port.waddr = MAP_AW'(cmd.item.tile_addr);
        tile_port.wdata = cmd.item.tile_shape;
        mask_port.we    = cmd_accept && (cmd.item.mode == MODE_WR_MASK)
                          && (32'(cmd.item.mask_shape) < SHAPE_COUNT);
        mask_port.waddr = {SHAPE_AW'(cmd.item.mask_shape), cmd.item.mask_row};
        mask_port.wdata = cmd.item.row_bits;

        tile_port.re    = 1'b0;
        tile_port.raddr = idx[MAP_AW-1:0];
        mask_port.re    = 1'b0;
        mask_port.raddr = {shape_reg, row_reg + 4'd1};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    x_next = cmd.item.pos_x;
                    y_next = cmd.item.pos_y;
                    if (cmd.item.mode == MODE_POINT)
                    begin
                        // a point is a one-pixel rectangle
                        w_next     = 15'd1;
                        h_next     = 15'd1;
                        state_next = S_CHECK;
                    end
                    else if (cmd.item.mode == MODE_AREA)
                    begin
                        w_next     = cmd.item.rect_w;
                        h_next     = cmd.item.rect_h;
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                tx0_next      = x_reg[14:4];
                ty0_next      = y_reg[14:4];
                tx1_next      = px1[14:4];
                ty1_next      = py1[14:4];
                tx_next       = x_reg[14:4];
                ty_next       = y_reg[14:4];
                px1_lo_next   = px1[3:0];
                py1_lo_next   = py1[3:0];
                row_base_next = ty0_ext * tpr_ext;
                if (empty)
                begin
                    finish = 1'b1;
                end
                else if (outside)
                begin
                    finish     = 1'b1;
                    finish_res = 1'b1;
                end
                else
                begin
                    state_next = S_TILE;
                end
            end

            S_TILE:
            begin
                if (!idx_in_map)
                begin
                    finish     = 1'b1;
                    finish_res = 1'b1;
                end
                else
                begin
                    tile_port.re = 1'b1;
                    state_next   = S_SHAPE;
                end
            end

            S_SHAPE:
            begin
                if (tile_rdata == SHAPE_FULL)
                begin
                    finish     = 1'b1;
                    finish_res = 1'b1;
                end
                else if ((tile_rdata == SHAPE_EMPTY) || (32'(tile_rdata) >= SHAPE_COUNT))
                begin
                    step_tile = 1'b1;
                end
                else
                begin
                    shape_next      = SHAPE_AW'(tile_rdata);
                    row_next        = r0;
                    last_row_next   = r1;
                    mk_next         = (ALL_COLS >> c0) & ~(TAIL_COLS >> c1);
                    mask_port.re    = 1'b1;
                    mask_port.raddr = {SHAPE_AW'(tile_rdata), r0};
                    state_next      = S_ROW;
                end
            end

            S_ROW:
            begin
                if ((mask_rdata & mk_reg) != '0)
                begin
                    finish     = 1'b1;
                    finish_res = 1'b1;
                end
                else if (row_reg == last_row_reg)
                begin
                    step_tile = 1'b1;
                end
                else
                begin
                    row_next     = row_reg + 4'd1;
                    mask_port.re = 1'b1;
                end
            end

            S_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_solid_next = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Move to the next tile of the rectangle, row by row
        if (step_tile)
        begin
            if (last_tx && last_ty)
            begin
                finish = 1'b1;
            end
            else if (last_tx)
            begin
                tx_next       = tx0_reg;
                ty_next       = ty_reg + TILE_W'(1);
                row_base_next = row_base_reg + tpr_ext;
                state_next    = S_TILE;
            end
            else
            begin
                tx_next    = tx_reg + TILE_W'(1);
                state_next = S_TILE;
            end
        end

        if (finish)
        begin
            res_next   = finish_res;
            state_next = S_DONE;
        end
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_solid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_solid_reg <= out_solid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        tx0_reg      <= tx0_next;
        tx1_reg      <= tx1_next;
        ty0_reg      <= ty0_next;
        ty1_reg      <= ty1_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        px1_lo_reg   <= px1_lo_next;
        py1_lo_reg   <= py1_lo_next;
        row_base_reg <= row_base_next;
        shape_reg    <= shape_next;
        row_reg      <= row_next;
        last_row_reg <= last_row_next;
        mk_reg       <= mk_next;
        res_reg      <= res_next;
    end

endmodule

### src/tile_mask_collision_test_core.sv
// Tile map collision tester.
// cmd channel (valid/ready, cmd_item_t): mode 0 writes a tile map entry,
// mode 1 writes one 16-bit row of a shape mask, mode 2 is a point query and
// mode 3 an area query. Writes give no result. Each query
// gives one item on rsp (rsp_item_t) with solid set if a solid pixel is hit.
// Registers tiles_per_row, map_width_px and map_height_px are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce it. A query walk does one tile
// map read, then one mask row read per cycle from the single read port of
// each store. An empty tile needs no mask row read, and a full tile or a hit
// ends the walk at once. cmd accepts one item at a time: ready is high only
// between queries. A result waits in the output register while rsp stalls;
// writes are still taken then, and a following query finishes its walk and
// holds until the register frees. Reset clears the sequencer and output valid
// and loads the register defaults; the stores are not cleared and must be
// written first.
module tile_mask_collision_test_core
    import tmct_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tmct_stream_if.sink      cmd,
    tmct_stream_if.source    rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    tile_port_t         tile_port;
    mask_port_t         mask_port;
    logic [SHAPE_W-1:0] tile_rdata;
    logic [ROW_W-1:0]   mask_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tiles_per_row <= TPR_RESET;
            cfg_reg.map_width_px  <= WIDTH_RESET;
            cfg_reg.map_height_px <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TILES_PER_ROW: cfg_reg.tiles_per_row <= cfg_data[TPR_W-1:0];
                CFG_MAP_WIDTH:     cfg_reg.map_width_px  <= cfg_data[PIX_W-1:0];
                CFG_MAP_HEIGHT:    cfg_reg.map_height_px <= cfg_data[PIX_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Tile map: one shape id per tile
    tmct_ram #(
        .DEPTH (MAP_ENTRIES),
        .WIDTH (SHAPE_W)
    ) u_tile_ram (
        .clk   (clk),
        .we    (tile_port.we),
        .waddr (tile_port.waddr),
        .wdata (tile_port.wdata),
        .re    (tile_port.re),
        .raddr (tile_port.raddr),
        .rdata (tile_rdata)
    );

    // Shape masks: sixteen rows per shape
    tmct_ram #(
        .DEPTH (MASK_DEPTH),
        .WIDTH (ROW_W)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_port.we),
        .waddr (mask_port.waddr),
        .wdata (mask_port.wdata),
        .re    (mask_port.re),
        .raddr (mask_port.raddr),
        .rdata (mask_rdata)
    );

    tmct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rsp        (rsp),
        .cfg        (cfg_reg),
        .tile_port  (tile_port),
        .tile_rdata (tile_rdata),
        .mask_port  (mask_port),
        .mask_rdata (mask_rdata)
    );

    // An accepted item never produces a result in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !$rose(rsp.valid))
        else $error("result appeared one cycle after an accepted item");

    // Stores are written only while no walk reads them
    assert property (@(posedge clk) disable iff (!rst_n)
        !(tile_port.we && tile_port.re))
        else $error("tile map read and written in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(mask_port.we && mask_port.re))
        else $error("mask table read and written in the same cycle");

    // Stores are only read while no new item can enter
    assert property (@(posedge clk) disable iff (!rst_n)
        (tile_port.re || mask_port.re) |-> !cmd.ready)
        else $error("store read while the command channel is open");

endmodule
